[rtl/cgsm_pkg.sv]
// ----------------------------------------------------------------------------
// cgsm_pkg
// Shared parameters, codes and tables of the Cyrillic glyph slot mapper.
// ----------------------------------------------------------------------------
package cgsm_pkg;

  localparam int GLYPH_SLOTS_DEF = 8;
  localparam int GLYPH_ROWS_DEF  = 8;

  localparam logic [1:0] KIND_CODE  = 2'd0;
  localparam logic [1:0] KIND_ROW   = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  localparam logic [7:0] CODE_IO_CAP   = 8'd168;
  localparam logic [7:0] CODE_IO_SMALL = 8'd184;
  localparam logic [7:0] CODE_CYR_BASE = 8'd192;
  localparam logic [5:0] GLYPH_MAX     = 6'd45;

  // Map entry for codes 192..255: Latin code, or bit 7 set and glyph index.
  function automatic logic [7:0] map_entry(input logic [5:0] idx);
    logic [7:0] e;
    case (idx)
      6'd0:  e = 8'h41; 6'd1:  e = 8'h80; 6'd2:  e = 8'h42; 6'd3:  e = 8'h81;
      6'd4:  e = 8'h82; 6'd5:  e = 8'h45; 6'd6:  e = 8'h83; 6'd7:  e = 8'h84;
      6'd8:  e = 8'h85; 6'd9:  e = 8'h86; 6'd10: e = 8'h4B; 6'd11: e = 8'h87;
      6'd12: e = 8'h4D; 6'd13: e = 8'h48; 6'd14: e = 8'h4F; 6'd15: e = 8'h88;
      6'd16: e = 8'h50; 6'd17: e = 8'h43; 6'd18: e = 8'h54; 6'd19: e = 8'h89;
      6'd20: e = 8'h8A; 6'd21: e = 8'h58; 6'd22: e = 8'h8B; 6'd23: e = 8'h8C;
      6'd24: e = 8'h8D; 6'd25: e = 8'h8E; 6'd26: e = 8'h8F; 6'd27: e = 8'h90;
      6'd28: e = 8'h91; 6'd29: e = 8'h92; 6'd30: e = 8'h93; 6'd31: e = 8'h94;
      6'd32: e = 8'h61; 6'd33: e = 8'h95; 6'd34: e = 8'h96; 6'd35: e = 8'h97;
      6'd36: e = 8'h98; 6'd37: e = 8'h65; 6'd38: e = 8'h99; 6'd39: e = 8'h9A;
      6'd40: e = 8'h9B; 6'd41: e = 8'h9C; 6'd42: e = 8'h9D; 6'd43: e = 8'h9E;
      6'd44: e = 8'h9F; 6'd45: e = 8'hA0; 6'd46: e = 8'h6F; 6'd47: e = 8'hA1;
      6'd48: e = 8'h70; 6'd49: e = 8'h63; 6'd50: e = 8'hA2; 6'd51: e = 8'h79;
      6'd52: e = 8'hA3; 6'd53: e = 8'h78; 6'd54: e = 8'hA4; 6'd55: e = 8'hA5;
      6'd56: e = 8'hA6; 6'd57: e = 8'hA7; 6'd58: e = 8'hA8; 6'd59: e = 8'hA9;
      6'd60: e = 8'hAA; 6'd61: e = 8'hAB; 6'd62: e = 8'hAC; default: e = 8'hAD;
    endcase
    return e;
  endfunction

  // Full 8-row glyph, row 0 in bits [39:35].
  function automatic logic [39:0] glyph(input logic [5:0] g);
    logic [39:0] v;
    case (g)
      6'd0:  v = {5'h1F,5'h10,5'h10,5'h1E,5'h11,5'h11,5'h1E,5'h00};
      6'd1:  v = {5'h1F,5'h10,5'h10,5'h10,5'h10,5'h10,5'h10,5'h00};
      6'd2:  v = {5'h06,5'h0A,5'h0A,5'h0A,5'h0A,5'h0A,5'h1F,5'h11};
      6'd3:  v = {5'h15,5'h15,5'h15,5'h0E,5'h15,5'h15,5'h15,5'h00};
      6'd4:  v = {5'h0E,5'h11,5'h01,5'h06,5'h01,5'h11,5'h0E,5'h00};
      6'd5:  v = {5'h11,5'h11,5'h11,5'h13,5'h15,5'h19,5'h11,5'h00};
      6'd6:  v = {5'h15,5'h11,5'h11,5'h13,5'h15,5'h19,5'h11,5'h00};
      6'd7:  v = {5'h07,5'h09,5'h09,5'h09,5'h09,5'h09,5'h11,5'h00};
      6'd8:  v = {5'h1F,5'h11,5'h11,5'h11,5'h11,5'h11,5'h11,5'h00};
      6'd9:  v = {5'h11,5'h11,5'h11,5'h0F,5'h01,5'h11,5'h0E,5'h00};
      6'd10: v = {5'h04,5'h0E,5'h15,5'h15,5'h15,5'h0E,5'h04,5'h00};
      6'd11: v = {5'h12,5'h12,5'h12,5'h12,5'h12,5'h12,5'h1F,5'h01};
      6'd12: v = {5'h11,5'h11,5'h11,5'h0F,5'h01,5'h01,5'h01,5'h00};
      6'd13: v = {5'h11,5'h11,5'h11,5'h15,5'h15,5'h15,5'h1F,5'h00};
      6'd14: v = {5'h11,5'h11,5'h11,5'h15,5'h15,5'h15,5'h1F,5'h01};
      6'd15: v = {5'h18,5'h08,5'h08,5'h0E,5'h09,5'h09,5'h0E,5'h00};
      6'd16: v = {5'h11,5'h11,5'h11,5'h1D,5'h13,5'h13,5'h1D,5'h00};
      6'd17: v = {5'h10,5'h10,5'h10,5'h1E,5'h11,5'h11,5'h1E,5'h00};
      6'd18: v = {5'h0E,5'h11,5'h01,5'h07,5'h01,5'h11,5'h0E,5'h00};
      6'd19: v = {5'h12,5'h15,5'h15,5'h1D,5'h15,5'h15,5'h12,5'h00};
      6'd20: v = {5'h0F,5'h11,5'h11,5'h0F,5'h05,5'h09,5'h11,5'h00};
      6'd21: v = {5'h03,5'h0C,5'h10,5'h1E,5'h11,5'h11,5'h0E,5'h00};
      6'd22: v = {5'h00,5'h00,5'h1E,5'h11,5'h1E,5'h11,5'h1E,5'h00};
      6'd23: v = {5'h00,5'h00,5'h1E,5'h10,5'h10,5'h10,5'h10,5'h00};
      6'd24: v = {5'h00,5'h00,5'h06,5'h0A,5'h0A,5'h0A,5'h1F,5'h11};
      6'd25: v = {5'h00,5'h00,5'h15,5'h15,5'h0E,5'h15,5'h15,5'h00};
      6'd26: v = {5'h00,5'h00,5'h0E,5'h11,5'h06,5'h11,5'h0E,5'h00};
      6'd27: v = {5'h00,5'h00,5'h11,5'h13,5'h15,5'h19,5'h11,5'h00};
      6'd28: v = {5'h0A,5'h04,5'h11,5'h13,5'h15,5'h19,5'h11,5'h00};
      6'd29: v = {5'h00,5'h00,5'h12,5'h14,5'h18,5'h14,5'h12,5'h00};
      6'd30: v = {5'h00,5'h00,5'h07,5'h09,5'h09,5'h09,5'h11,5'h00};
      6'd31: v = {5'h00,5'h00,5'h11,5'h1B,5'h15,5'h11,5'h11,5'h00};
      6'd32: v = {5'h00,5'h00,5'h11,5'h11,5'h1F,5'h11,5'h11,5'h00};
      6'd33: v = {5'h00,5'h00,5'h1F,5'h11,5'h11,5'h11,5'h11,5'h00};
      6'd34: v = {5'h00,5'h00,5'h1F,5'h04,5'h04,5'h04,5'h04,5'h00};
      6'd35: v = {5'h00,5'h00,5'h04,5'h0E,5'h15,5'h0E,5'h04,5'h00};
      6'd36: v = {5'h00,5'h00,5'h12,5'h12,5'h12,5'h12,5'h1F,5'h01};
      6'd37: v = {5'h00,5'h00,5'h11,5'h11,5'h0F,5'h01,5'h01,5'h00};
      6'd38: v = {5'h00,5'h00,5'h15,5'h15,5'h15,5'h15,5'h1F,5'h00};
      6'd39: v = {5'h00,5'h00,5'h15,5'h15,5'h15,5'h15,5'h1F,5'h01};
      6'd40: v = {5'h00,5'h00,5'h18,5'h08,5'h0E,5'h09,5'h0E,5'h00};
      6'd41: v = {5'h00,5'h00,5'h11,5'h11,5'h1D,5'h13,5'h1D,5'h00};
      6'd42: v = {5'h00,5'h00,5'h10,5'h10,5'h1E,5'h11,5'h1E,5'h00};
      6'd43: v = {5'h00,5'h00,5'h0E,5'h11,5'h07,5'h11,5'h0E,5'h00};
      6'd44: v = {5'h00,5'h00,5'h12,5'h15,5'h1D,5'h15,5'h12,5'h00};
      default: v = {5'h00,5'h00,5'h0F,5'h11,5'h0F,5'h05,5'h09,5'h00};
    endcase
    return v;
  endfunction

endpackage

[rtl/cyrillic_glyph_slot_mapper.sv]
// ----------------------------------------------------------------------------
// cyrillic_glyph_slot_mapper
// Maps single-byte Cyrillic codes to display codes, loading user glyphs.
// ----------------------------------------------------------------------------
// Flow: a clear loads its beat at accept; a pass-through or Latin look-alike
//   is decoded in S_DECODE first; a glyph code walks the slot tags with one
//   shared comparator, one tag per cycle, then on a miss emits 8 rows
//   and the slot number, one beat per cycle when the sink is ready.
// Items: one item at a time; a new code is taken only back in S_IDLE.
// Reset: rst clears tags, pointer and sequencer state; no clearing pass.
module cyrillic_glyph_slot_mapper
  import cgsm_pkg::*;
#(
  parameter int GLYPH_SLOTS = GLYPH_SLOTS_DEF,
  parameter int GLYPH_ROWS  = GLYPH_ROWS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       mode,
  input  logic [7:0] char_code,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] kind,
  output logic [2:0] slot,
  output logic [2:0] row,
  output logic [4:0] row_bits,
  output logic [7:0] code,
  output logic       last
);

  localparam int SW = (GLYPH_SLOTS > 1) ? $clog2(GLYPH_SLOTS) : 1;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_DECODE = 5'b00010,
    S_SEARCH = 5'b00100,
    S_ROWS   = 5'b01000,
    S_OUT    = 5'b10000
  } state_t;

  state_t      state;
  logic [7:0]  ch;
  logic [5:0]  gidx;
  logic [7:0]  tags [GLYPH_SLOTS];
  logic [SW-1:0] probe;
  logic [SW-1:0] next_slot;
  logic [2:0]  row_cnt;
  logic [39:0] rows_sr;

  // decode of the latched code
  logic [7:0] ch_m;
  logic [7:0] entry;
  logic       hit;
  logic       probe_end;
  logic [39:0] glyph_bits;

  always_comb begin
    ch_m = ch;
    if (ch == CODE_IO_CAP) ch_m = 8'h45;
    else if (ch == CODE_IO_SMALL) ch_m = 8'h65;
    entry = map_entry(ch_m[5:0]);
    // shared comparator: one tag per cycle
    hit = (tags[probe] == ch_m);
    probe_end = (32'(probe) == GLYPH_SLOTS - 1);
    glyph_bits = glyph(gidx);
  end

  assign in_ready = (state == S_IDLE);

  logic out_fire;
  assign out_fire = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      next_slot <= '0;
      for (int i = 0; i < GLYPH_SLOTS; i++) tags[i] <= 8'd0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (mode) begin
              for (int i = 0; i < GLYPH_SLOTS; i++) tags[i] <= 8'd0;
              next_slot <= '0;
              kind <= KIND_CLEAR; slot <= 3'd0; row <= 3'd0;
              row_bits <= 5'd0; code <= 8'd0; last <= 1'b1;
              out_valid <= 1'b1;
              state <= S_OUT;
            end else begin
              ch    <= char_code;
              probe <= '0;
              state <= S_DECODE;
            end
          end
        end
        S_DECODE: begin
          kind <= KIND_CODE; slot <= 3'd0; row <= 3'd0;
          row_bits <= 5'd0; last <= 1'b1;
          if (ch_m < CODE_CYR_BASE) begin
            code <= ch_m; out_valid <= 1'b1; state <= S_OUT;
          end else if (!entry[7]) begin
            code <= entry; out_valid <= 1'b1; state <= S_OUT;
          end else begin
            gidx  <= (entry[5:0] > GLYPH_MAX) ? GLYPH_MAX : entry[5:0];
            state <= S_SEARCH;
          end
        end
        S_SEARCH: begin
          if (hit) begin
            code <= 8'(probe); out_valid <= 1'b1; state <= S_OUT;
          end else if (probe_end) begin
            tags[next_slot] <= ch_m;
            rows_sr  <= glyph_bits;
            row_cnt  <= 3'd0;
            kind     <= KIND_ROW;
            slot     <= 3'(next_slot);
            row      <= 3'd0;
            row_bits <= glyph_bits[39:35];
            code     <= 8'd0;
            last     <= 1'b0;
            out_valid <= 1'b1;
            state    <= S_ROWS;
          end else begin
            probe <= probe + 1'b1;
          end
        end
        S_ROWS: begin
          if (out_fire) begin
            if (32'(row_cnt) == GLYPH_ROWS - 1) begin
              kind <= KIND_CODE; row <= 3'd0; row_bits <= 5'd0;
              slot <= 3'd0; code <= 8'(next_slot); last <= 1'b1;
              next_slot <= (32'(next_slot) == GLYPH_SLOTS - 1) ? '0 : next_slot + 1'b1;
              state <= S_OUT;
            end else begin
              row_cnt  <= row_cnt + 3'd1;
              row      <= row_cnt + 3'd1;
              row_bits <= rows_sr[34:30];
              rows_sr  <= {rows_sr[34:0], 5'd0};
            end
          end
        end
        S_OUT: begin
          if (out_fire) begin
            out_valid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
